FILE: sv/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ctt_pkg.sv
package ctt_pkg;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam int         FIN_BIT   = 0;
   localparam int         ACK_BIT   = 4;

   typedef enum logic [1:0] {
      VERDICT_INVALID     = 2'd0,
      VERDICT_NEW         = 2'd1,
      VERDICT_ESTABLISHED = 2'd2,
      VERDICT_NO_ROOM     = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      PHASE_SYN_SENT    = 2'd0,
      PHASE_ESTABLISHED = 2'd1,
      PHASE_FIN_WAIT    = 2'd2,
      PHASE_NONE        = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_PACKET  = 2'd1,
      KIND_SWEEP   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        tcp;
      logic        fin;
      logic        ack;
      logic        same;
      logic [63:0] fwd_addr;
      logic [39:0] fwd_pp;
      logic [63:0] rev_addr;
      logic [39:0] rev_pp;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic [63:0] addr;
      logic [39:0] pp;
      phase_type   phase;
      logic [31:0] stamp;
   } entry_type;

endpackage

FILE: sv/ctt_ram.sv
module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ctt_front.sv
module ctt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic              req_has_ipv4,
   input  logic              req_has_l4,
   input  logic [31:0]       req_src_ip,
   input  logic [31:0]       req_dst_ip,
   input  logic [15:0]       req_src_port,
   input  logic [15:0]       req_dst_port,
   input  logic [7:0]        req_protocol,
   input  logic [7:0]        req_tcp_flags,
   input  logic [31:0]       req_now,
   output logic              q_valid,
   output ctt_pkg::item_type q_item,
   input  logic              q_pop
);
   import ctt_pkg::*;

   item_type   item_in;
   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   always_comb begin
      item_in.fwd_addr = {req_src_ip, req_dst_ip};
      item_in.fwd_pp   = {req_src_port, req_dst_port, req_protocol};
      item_in.rev_addr = {req_dst_ip, req_src_ip};
      item_in.rev_pp   = {req_dst_port, req_src_port, req_protocol};
      item_in.tcp      = (req_protocol == PROTO_TCP);
      item_in.fin      = req_tcp_flags[FIN_BIT];
      item_in.ack      = req_tcp_flags[ACK_BIT];
      item_in.same     = (req_src_ip == req_dst_ip) && (req_src_port == req_dst_port);
      item_in.now      = req_now;
      if (req_operation) begin
         item_in.kind = KIND_SWEEP;
      end else if (req_has_ipv4 && req_has_l4) begin
         item_in.kind = KIND_PACKET;
      end else begin
         item_in.kind = KIND_INVALID;
      end
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

FILE: sv/ctt_back.sv
module ctt_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       idle_timeout,
   input  logic              q_valid,
   input  ctt_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_verdict,
   output logic [1:0]        rsp_tcp_phase,
   output logic [6:0]        rsp_entry_count
);
   import ctt_pkg::*;
   `include "assert_macros.svh"

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   typedef enum logic [6:0] {
      ST_CLR    = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_TAIL   = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_WR2    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff;
   item_type    item_ff, item_in;
   logic        fwd_hit_ff, fwd_hit_in, rev_hit_ff, rev_hit_in;
   logic [IW-1:0] fwd_idx_ff, fwd_idx_in, rev_idx_ff, rev_idx_in;
   phase_type   fwd_ph_ff, fwd_ph_in, rev_ph_ff, rev_ph_in;
   logic        f1_ok_ff, f1_ok_in, f2_ok_ff, f2_ok_in;
   logic [IW-1:0] f1_idx_ff, f1_idx_in, f2_idx_ff, f2_idx_in;
   logic [CW-1:0] count_ff, count_in;
   verdict_type res_verdict_ff, res_verdict_in;
   phase_type   res_phase_ff, res_phase_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_verdict_ff, rsp_phase_ff;
   logic [6:0]  rsp_count_ff;
   logic        rsp_load;

   logic          v_we, v_wdata, v_rdata;
   logic [IW-1:0] v_waddr;
   logic          e_we;
   logic [IW-1:0] e_waddr;
   entry_type     e_wdata, e_rdata;
   logic [EW-1:0] e_rdata_raw;

   logic       match_f, match_r, expire;
   logic [31:0] age;
   phase_type  new_fph, new_rph, start_ph;
   logic       room;
   logic [CW+6:0] cnt_wide;
   logic [6:0]    cnt_out;

   ctt_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .raddr (idx_ff),
      .rdata (v_rdata)
   );

   ctt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (idx_ff),
      .rdata (e_rdata_raw)
   );

   assign e_rdata = entry_type'(e_rdata_raw);

   always_comb begin
      age     = item_ff.now - e_rdata.stamp;
      match_f = cmp_vld_ff && v_rdata && (e_rdata.addr == item_ff.fwd_addr)
                && (e_rdata.pp == item_ff.fwd_pp);
      match_r = cmp_vld_ff && v_rdata && (e_rdata.addr == item_ff.rev_addr)
                && (e_rdata.pp == item_ff.rev_pp);
      expire  = cmp_vld_ff && v_rdata && (item_ff.kind == KIND_SWEEP)
                && (age > idle_timeout);
      if (item_ff.tcp && item_ff.fin) begin
         new_fph = PHASE_FIN_WAIT;
      end else if (item_ff.tcp && item_ff.ack) begin
         new_fph = PHASE_ESTABLISHED;
      end else begin
         new_fph = fwd_ph_ff;
      end
      new_rph  = (item_ff.tcp && item_ff.ack) ? PHASE_ESTABLISHED : rev_ph_ff;
      start_ph = item_ff.tcp ? PHASE_SYN_SENT : PHASE_ESTABLISHED;
      room     = f1_ok_ff && (item_ff.same || f2_ok_ff);
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cmp_vld_in     = 1'b0;
      item_in        = item_ff;
      fwd_hit_in     = fwd_hit_ff;
      fwd_idx_in     = fwd_idx_ff;
      fwd_ph_in      = fwd_ph_ff;
      rev_hit_in     = rev_hit_ff;
      rev_idx_in     = rev_idx_ff;
      rev_ph_in      = rev_ph_ff;
      f1_ok_in       = f1_ok_ff;
      f1_idx_in      = f1_idx_ff;
      f2_ok_in       = f2_ok_ff;
      f2_idx_in      = f2_idx_ff;
      count_in       = count_ff;
      res_verdict_in = res_verdict_ff;
      res_phase_in   = res_phase_ff;
      v_we           = 1'b0;
      v_waddr        = cmp_idx_ff;
      v_wdata        = 1'b0;
      e_we           = 1'b0;
      e_waddr        = f1_idx_ff;
      e_wdata        = '{addr: item_ff.fwd_addr, pp: item_ff.fwd_pp,
                         phase: start_ph, stamp: item_ff.now};

      // compare stage, runs in the cycle after the read address is applied
      if (match_f && !fwd_hit_ff) begin
         fwd_hit_in = 1'b1;
         fwd_idx_in = cmp_idx_ff;
         fwd_ph_in  = e_rdata.phase;
      end
      if (match_r && !rev_hit_ff) begin
         rev_hit_in = 1'b1;
         rev_idx_in = cmp_idx_ff;
         rev_ph_in  = e_rdata.phase;
      end
      if (cmp_vld_ff && !v_rdata) begin
         if (!f1_ok_ff) begin
            f1_ok_in  = 1'b1;
            f1_idx_in = cmp_idx_ff;
         end else if (!f2_ok_ff) begin
            f2_ok_in  = 1'b1;
            f2_idx_in = cmp_idx_ff;
         end
      end
      if (expire) begin
         v_we     = 1'b1;
         count_in = count_ff - CW'(1);
      end

      unique case (state_ff)
         ST_CLR: begin
            v_we    = 1'b1;
            v_waddr = idx_ff;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               item_in    = q_item;
               idx_in     = '0;
               fwd_hit_in = 1'b0;
               rev_hit_in = 1'b0;
               f1_ok_in   = 1'b0;
               f2_ok_in   = 1'b0;
               if (q_item.kind == KIND_INVALID) begin
                  res_verdict_in = VERDICT_INVALID;
                  res_phase_in   = PHASE_NONE;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_TAIL;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_TAIL: begin
            if (item_ff.kind == KIND_SWEEP) begin
               res_verdict_in = VERDICT_INVALID;
               res_phase_in   = PHASE_NONE;
               state_in       = ST_DONE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (fwd_hit_ff) begin
               e_we           = 1'b1;
               e_waddr        = fwd_idx_ff;
               e_wdata.phase  = new_fph;
               res_verdict_in = VERDICT_ESTABLISHED;
               res_phase_in   = new_fph;
            end else if (rev_hit_ff) begin
               e_we           = 1'b1;
               e_waddr        = rev_idx_ff;
               e_wdata        = '{addr: item_ff.rev_addr, pp: item_ff.rev_pp,
                                  phase: new_rph, stamp: item_ff.now};
               res_verdict_in = VERDICT_ESTABLISHED;
               res_phase_in   = new_rph;
            end else if (!room) begin
               res_verdict_in = VERDICT_NO_ROOM;
               res_phase_in   = PHASE_NONE;
            end else begin
               e_we           = 1'b1;
               v_we           = 1'b1;
               v_waddr        = f1_idx_ff;
               v_wdata        = 1'b1;
               count_in       = count_ff + CW'(1);
               res_verdict_in = VERDICT_NEW;
               res_phase_in   = start_ph;
               if (!item_ff.same) begin
                  state_in = ST_WR2;
               end
            end
         end
         ST_WR2: begin
            e_we     = 1'b1;
            e_waddr  = f2_idx_ff;
            e_wdata  = '{addr: item_ff.rev_addr, pp: item_ff.rev_pp,
                         phase: start_ph, stamp: item_ff.now};
            v_we     = 1'b1;
            v_waddr  = f2_idx_ff;
            v_wdata  = 1'b1;
            count_in = count_ff + CW'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_wide     = {7'd0, count_ff};
      cnt_out      = (cnt_wide > (CW + 7)'(127)) ? 7'd127 : cnt_wide[6:0];
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rev_hit_ff   <= 1'b0;
         f1_ok_ff     <= 1'b0;
         f2_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rev_hit_ff   <= rev_hit_in;
         f1_ok_ff     <= f1_ok_in;
         f2_ok_ff     <= f2_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff     <= idx_ff;
      item_ff        <= item_in;
      fwd_idx_ff     <= fwd_idx_in;
      fwd_ph_ff      <= fwd_ph_in;
      rev_idx_ff     <= rev_idx_in;
      rev_ph_ff      <= rev_ph_in;
      f1_idx_ff      <= f1_idx_in;
      f2_idx_ff      <= f2_idx_in;
      res_verdict_ff <= res_verdict_in;
      res_phase_ff   <= res_phase_in;
      if (rsp_load) begin
         rsp_verdict_ff <= res_verdict_ff;
         rsp_phase_ff   <= res_phase_ff;
         rsp_count_ff   <= cnt_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_tcp_phase   = rsp_phase_ff;
   assign rsp_entry_count = rsp_count_ff;

   `AST_NOW(a_count_bound, clock, reset, 1'b1, ({1'b0, count_ff} <= (CW + 1)'(TABLE_DEPTH)), "entry count above table depth")
   `AST_NOW(a_wr2_slot, clock, reset, state_ff == ST_WR2, f2_ok_ff, "second store without a free slot")
   `AST_NOW(a_no_pop_clr, clock, reset, state_ff == ST_CLR, !q_pop, "item taken during clearing pass")
   `AST_NEXT(a_scan_tail, clock, reset, state_ff == ST_TAIL, cmp_vld_ff == 1'b0, "compare stage busy after scan")

endmodule

FILE: sv/connection_tracking_table.sv
// Connection tracking table.
// req_ channel: one beat per packet or sweep, taken when req_valid is high
//   and req_stall low. A two-beat queue sits in front of the lookup engine.
// rsp_ channel: one beat per request, in request order, held while rsp_stall.
// CSR port (APB style): register idle_timeout at byte address 0.
// Every valid packet or sweep scans all TABLE_DEPTH slots through the entry
// RAM read port, one slot a cycle; a sweep then passes a tail state, a packet
// also a decide state, and a new two-entry flow a second write state too. An
// invalid packet skips the scan. The scan through the single RAM read port
// sets the rate. After reset a clearing pass over all TABLE_DEPTH slots
// zeroes the valid bits; requests queue but are not processed until it
// ends. CSR writes are taken at any time. A stalled response keeps the
// engine waiting; the queue keeps accepting up to two beats.
module connection_tracking_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic        req_has_ipv4,
   input  logic        req_has_l4,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_protocol,
   input  logic [7:0]  req_tcp_flags,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [1:0]  rsp_tcp_phase,
   output logic [6:0]  rsp_entry_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ctt_pkg::*;

   localparam logic [2:0] ADDR_IDLE_TIMEOUT = 3'd0;

   logic [31:0] timeout_ff, timeout_in;
   logic        q_valid, q_pop;
   item_type    q_item;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_IDLE_TIMEOUT) ? timeout_ff : 32'd0;

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && (paddr == ADDR_IDLE_TIMEOUT)) begin
         timeout_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 32'd1000000;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ctt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_has_ipv4  (req_has_ipv4),
      .req_has_l4    (req_has_l4),
      .req_src_ip    (req_src_ip),
      .req_dst_ip    (req_dst_ip),
      .req_src_port  (req_src_port),
      .req_dst_port  (req_dst_port),
      .req_protocol  (req_protocol),
      .req_tcp_flags (req_tcp_flags),
      .req_now       (req_now),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   ctt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .idle_timeout    (timeout_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_tcp_phase   (rsp_tcp_phase),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
